### rtl/aes_block_cipher_unit_assert.svh
// Assertion macros for the AES block cipher unit
`ifndef AES_BLOCK_CIPHER_UNIT_ASSERT_SVH
`define AES_BLOCK_CIPHER_UNIT_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define AES_ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
// implication checked in the next cycle
`define AES_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`endif

### rtl/aes_pkg.sv
// Shared types, constants and byte functions for the AES block cipher unit
package aes_pkg;
   localparam int StoreDepth = 60;
   localparam int AddrW = 6;

   localparam logic [2:0] CsrKeySize = 3'd0;
   localparam logic [2:0] CsrKey0 = 3'd1;
   localparam logic [2:0] CsrKey1 = 3'd2;
   localparam logic [2:0] CsrKey2 = 3'd3;
   localparam logic [2:0] CsrKey3 = 3'd4;

   localparam logic CmdEncrypt = 1'b0;
   localparam logic CmdDecrypt = 1'b1;

   // controller commands to the datapath
   typedef struct packed {
      logic key_load;     // copy key registers into first schedule words
      logic key_step;     // compute and store one schedule word
      logic blk_load;     // load state from input and request first round key
      logic rnd_step;     // apply one round (key word group already read)
      logic rnd_first;    // initial key addition only
      logic rnd_last;     // final round without MixColumns
      logic rsp_load;     // move state to output register
      logic [AddrW-1:0] key_idx;  // schedule word being written
      logic [3:0] rnd_idx;        // round key group to read
   } ctl_type;

   // datapath status to the controller
   typedef struct packed {
      logic       dec;
      logic [3:0] nr;
      logic [3:0] nk;
   } sts_type;

   function automatic logic [7:0] sbox(input logic [7:0] a);
      logic [7:0] t [256];
      t = '{
      8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
      8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
      8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
      8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
      8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
      8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
      8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
      8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
      8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
      8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
      8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
      8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
      8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
      8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
      8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
      8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16};
      return t[a];
   endfunction

   function automatic logic [7:0] isbox(input logic [7:0] a);
      logic [7:0] t [256];
      t = '{
      8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
      8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
      8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
      8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
      8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
      8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
      8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
      8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
      8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
      8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
      8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
      8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
      8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
      8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
      8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D};
      return t[a];
   endfunction

   // multiply by x in GF(2^8)
   function automatic logic [7:0] xt(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
   endfunction

   // forward MixColumns on one column, first byte in top bits
   function automatic logic [31:0] mix_fwd(input logic [31:0] c);
      logic [7:0] a0, a1, a2, a3;
      a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
      return {xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3,
              a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3,
              a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3,
              xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3)};
   endfunction

   // inverse MixColumns: premultiply then forward mix
   function automatic logic [31:0] mix_inv(input logic [31:0] c);
      logic [7:0] u, v;
      u = xt(xt(c[31:24] ^ c[15:8]));
      v = xt(xt(c[23:16] ^ c[7:0]));
      return mix_fwd({c[31:24] ^ u, c[23:16] ^ v, c[15:8] ^ u, c[7:0] ^ v});
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
   endfunction
endpackage

### rtl/aes_block_cipher_unit.sv
// Top level of the AES block cipher unit
// A block is accepted only while the unit is idle. It goes through the initial key addition,
// one round per cycle in the shared round unit and a move to the output register, which waits
// while an earlier result is still unread; no new block is taken until the result is loaded
// there. A key or key size write starts a schedule expansion, one word per cycle unless a
// further write restarts it, during which no block is accepted. The round key store is four
// 15-word banks read once per round.
module aes_block_cipher_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // block_hi[63:0], block_lo[127:64]
   input  logic         req_tuser,   // cmd
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,   // result_hi[63:0], result_lo[127:64]
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [63:0]  csr_data
);
   import aes_pkg::*;

   ctl_type ctl;
   sts_type sts;
   logic csr_write;
   logic [127:0] req_block;
   logic [127:0] rsp_block;
   logic [3:0] cmd_bits;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && (csr_index <= CsrKey3);

   // datapath holds the block with byte 0 in the top bits
   assign req_block = {req_tdata[63:0], req_tdata[127:64]};
   assign rsp_tdata = {rsp_block[63:0], rsp_block[127:64]};

   aes_ctrl u_ctrl (
      .clock(clock), .reset(reset), .csr_write(csr_write),
      .req_tvalid(req_tvalid), .req_cmd(req_tuser), .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .sts(sts), .ctl(ctl)
   );

   aes_dpath u_dpath (
      .clock(clock), .reset(reset), .csr_valid(csr_valid), .csr_index(csr_index),
      .csr_data(csr_data), .req_cmd(req_tuser), .req_block(req_block),
      .rsp_block(rsp_block), .ctl(ctl), .sts(sts)
   );

   assign cmd_bits = {ctl.key_load, ctl.key_step, ctl.blk_load, ctl.rsp_load};

`include "aes_block_cipher_unit_assert.svh"
   `AES_ASSERT_IMPLY(a_one_cmd, clock, reset, 1'b1, $onehot0(cmd_bits))
   `AES_ASSERT_NEXT(a_accept_busy, clock, reset, req_tvalid && req_tready, !req_tready)
   `AES_ASSERT_IMPLY(a_rsp_from_load, clock, reset, $rose(rsp_tvalid), $past(ctl.rsp_load))
endmodule

### rtl/aes_ctrl.sv
// Controller state machine: key expansion sequencing and round sequencing
module aes_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write,
   input  logic             req_tvalid,
   input  logic             req_cmd,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  aes_pkg::sts_type sts,
   output aes_pkg::ctl_type ctl
);
   import aes_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_KEXP = 5'b00010,
      ST_FIRST = 5'b00100,
      ST_ROUND = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic [AddrW-1:0] kidx_ff, kidx_in;
   logic [3:0] rcnt_ff, rcnt_in;
   logic kload_ff, kload_in;
   logic rv_ff, rv_in;
   logic [AddrW-1:0] total;

   // schedule length 4*(nr+1)
   assign total = AddrW'({sts.nr, 2'b00} + 6'd4);

   // next state and commands; the round key group is read in the cycle before its use
   always_comb begin
      state_in = state_ff;
      kidx_in = kidx_ff;
      rcnt_in = rcnt_ff;
      kload_in = 1'b0;
      rv_in = rv_ff;
      ctl = '0;
      ctl.key_idx = kidx_ff;
      if (rv_ff && rsp_tready) begin
         rv_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            // group for the initial key addition of the block on offer
            ctl.rnd_idx = (req_cmd == CmdDecrypt) ? sts.nr : 4'd0;
            if (csr_write) begin
               kload_in = 1'b1;
            end else if (kload_ff) begin
               ctl.key_load = 1'b1;
               kidx_in = AddrW'(sts.nk);
               state_in = ST_KEXP;
            end else if (req_tvalid) begin
               ctl.blk_load = 1'b1;
               rcnt_in = 4'd0;
               state_in = ST_FIRST;
            end
         end
         ST_KEXP: begin
            if (csr_write) begin
               kload_in = 1'b1;
               state_in = ST_IDLE;
            end else begin
               ctl.key_step = 1'b1;
               kidx_in = kidx_ff + 1'b1;
               if (kidx_ff == total - 1'b1) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_FIRST: begin
            ctl.rnd_first = 1'b1;
            ctl.rnd_step = 1'b1;
            rcnt_in = 4'd1;
            ctl.rnd_idx = sts.dec ? 4'(sts.nr - rcnt_in) : rcnt_in;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            ctl.rnd_step = 1'b1;
            ctl.rnd_last = (rcnt_ff == sts.nr);
            rcnt_in = rcnt_ff + 1'b1;
            if (rcnt_ff == sts.nr) begin
               state_in = ST_DONE;
            end else begin
               ctl.rnd_idx = sts.dec ? 4'(sts.nr - rcnt_in) : rcnt_in;
            end
         end
         ST_DONE: begin
            if (!rv_ff || rsp_tready) begin
               ctl.rsp_load = 1'b1;
               rv_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE) && !csr_write && !kload_ff;
   assign rsp_tvalid = rv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         kidx_ff <= '0;
         rcnt_ff <= '0;
         kload_ff <= 1'b0;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         kidx_ff <= kidx_in;
         rcnt_ff <= rcnt_in;
         kload_ff <= kload_in;
         rv_ff <= rv_in;
      end
   end
endmodule

### rtl/aes_dpath.sv
// Datapath: key registers, round key store, shared round unit, output register
module aes_dpath (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   input  logic [2:0]       csr_index,
   input  logic [63:0]      csr_data,
   input  logic             req_cmd,
   input  logic [127:0]     req_block,
   output logic [127:0]     rsp_block,
   input  aes_pkg::ctl_type ctl,
   output aes_pkg::sts_type sts
);
   import aes_pkg::*;

   logic [1:0] ksize_ff;
   logic [63:0] kw_ff [4];
   logic [127:0] st_ff, st_in;
   logic [127:0] out_ff;
   logic dec_ff;
   logic [127:0] rk_ff;          // registered round key group
   logic [31:0] ram0 [StoreDepth/4];
   logic [31:0] ram1 [StoreDepth/4];
   logic [31:0] ram2 [StoreDepth/4];
   logic [31:0] ram3 [StoreDepth/4];
   logic [31:0] win_ff [8];      // last nk schedule words
   logic [7:0] rcon_ff;
   logic [3:0] cnt_ff;           // position within key period
   logic [31:0] prev, t, nw;
   logic [3:0] nk;
   logic [1:0] ks;

   assign ks = (ksize_ff == 2'd3) ? 2'd2 : ksize_ff;
   assign nk = 4'd4 + {1'b0, ks, 1'b0};
   assign sts.nk = nk;
   assign sts.nr = nk + 4'd6;
   assign sts.dec = dec_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ksize_ff <= 2'd0;
         kw_ff[0] <= '0; kw_ff[1] <= '0; kw_ff[2] <= '0; kw_ff[3] <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CsrKeySize: ksize_ff <= csr_data[1:0];
            CsrKey0: kw_ff[0] <= csr_data;
            CsrKey1: kw_ff[1] <= csr_data;
            CsrKey2: kw_ff[2] <= csr_data;
            CsrKey3: kw_ff[3] <= csr_data;
            default: ;
         endcase
      end
   end

   // next schedule word from window: w[i-1] at nk-1, w[i-nk] at 0
   always_comb begin
      prev = win_ff[nk[2:0] - 3'd1];
      t = prev;
      if (cnt_ff == 4'd0) begin
         t = sub_word({prev[23:0], prev[31:24]}) ^ {rcon_ff, 24'h0};
      end else if (nk == 4'd8 && cnt_ff == 4'd4) begin
         t = sub_word(prev);
      end
      nw = win_ff[0] ^ t;
   end

   // key expansion: window shift register and round key store writes
   always_ff @(posedge clock) begin
      if (ctl.key_load) begin
         for (int i = 0; i < 8; i++) begin
            win_ff[i] <= i[0] ? kw_ff[i/2][31:0] : kw_ff[i/2][63:32];
         end
         ram0[0] <= kw_ff[0][63:32]; ram1[0] <= kw_ff[0][31:0];
         ram2[0] <= kw_ff[1][63:32]; ram3[0] <= kw_ff[1][31:0];
         ram0[1] <= kw_ff[2][63:32]; ram1[1] <= kw_ff[2][31:0];
         ram2[1] <= kw_ff[3][63:32]; ram3[1] <= kw_ff[3][31:0];
         rcon_ff <= 8'h01;
         cnt_ff <= 4'd0;
      end else if (ctl.key_step) begin
         for (int i = 0; i < 7; i++) begin
            win_ff[i] <= win_ff[i+1];
         end
         win_ff[nk[2:0] - 3'd1] <= nw;
         case (ctl.key_idx[1:0])
            2'd0: ram0[ctl.key_idx[AddrW-1:2]] <= nw;
            2'd1: ram1[ctl.key_idx[AddrW-1:2]] <= nw;
            2'd2: ram2[ctl.key_idx[AddrW-1:2]] <= nw;
            default: ram3[ctl.key_idx[AddrW-1:2]] <= nw;
         endcase
         if (cnt_ff == nk - 4'd1) begin
            cnt_ff <= 4'd0;
            rcon_ff <= xt(rcon_ff);
         end else begin
            cnt_ff <= cnt_ff + 1'b1;
         end
      end
   end

   // round key group read, registered
   always_ff @(posedge clock) begin
      rk_ff <= {ram0[ctl.rnd_idx], ram1[ctl.rnd_idx], ram2[ctl.rnd_idx], ram3[ctl.rnd_idx]};
   end

   // one round per cycle
   always_comb begin
      logic [7:0] b [16];
      logic [7:0] s [16];
      logic [127:0] x;
      logic [127:0] y;
      for (int i = 0; i < 16; i++) begin
         b[i] = st_ff[127-8*i -: 8];
      end
      for (int i = 0; i < 16; i++) begin
         s[i] = dec_ff ? isbox(b[(i & 3) + 4*(((i >> 2) - (i & 3)) & 3)])
                       : sbox(b[(i & 3) + 4*(((i >> 2) + (i & 3)) & 3)]);
      end
      for (int i = 0; i < 16; i++) begin
         x[127-8*i -: 8] = s[i];
      end
      y = x;
      if (!dec_ff && !ctl.rnd_last) begin
         for (int c = 0; c < 4; c++) begin
            y[127-32*c -: 32] = mix_fwd(x[127-32*c -: 32]);
         end
      end
      st_in = y ^ rk_ff;
      if (dec_ff && !ctl.rnd_last) begin
         for (int c = 0; c < 4; c++) begin
            st_in[127-32*c -: 32] = mix_inv(st_in[127-32*c -: 32]);
         end
      end
      if (ctl.rnd_first) begin
         st_in = st_ff ^ rk_ff;
      end
   end

   // state and output registers
   always_ff @(posedge clock) begin
      if (ctl.blk_load) begin
         st_ff <= req_block;
         dec_ff <= (req_cmd == CmdDecrypt);
      end else if (ctl.rnd_step) begin
         st_ff <= st_in;
      end
      if (ctl.rsp_load) begin
         out_ff <= st_ff;
      end
   end

   assign rsp_block = out_ff;
endmodule

### dv/testbench.sv
// Self-checking testbench for the AES block cipher unit (ECB, 128/192/256-bit keys)
`timescale 1ns / 1ps

module testbench;
   import aes_pkg::*;

   localparam logic [2:0] CsrUnused = 3'd5;   // index past the last register
   localparam int IdleLimit = 5000;
   localparam int DrainCycles = 24;           // extra wait after the last expected result is checked

   logic         clock, reset;
   logic         req_tvalid, req_tready, req_tuser;
   logic [127:0] req_tdata;
   logic         rsp_tvalid, rsp_tready;
   logic [127:0] rsp_tdata;
   logic         csr_valid, csr_ready;
   logic [2:0]   csr_index;
   logic [63:0]  csr_data;

   aes_block_cipher_unit u_dut (.*);

   // directed stimulus row; rekey loads all five registers first
   typedef struct {
      bit         rekey;
      bit [1:0]   ks;
      bit [63:0]  k0, k1, k2, k3;
      bit         cmd;
      bit [63:0]  hi, lo;
      bit         known;
      bit [127:0] ans;
   } dir_row_type;

   localparam bit [63:0] F0 = 64'h0001020304050607, F1 = 64'h08090a0b0c0d0e0f;
   localparam bit [63:0] F2 = 64'h1011121314151617, F3 = 64'h18191a1b1c1d1e1f;
   localparam bit [63:0] PH = 64'h0011223344556677, PL = 64'h8899aabbccddeeff;
   localparam bit [63:0] ONES = '1;

   dir_row_type dir_rows [] = '{
      '{1, 0, F0, F1, 0, 0, CmdEncrypt, PH, PL, 1, 128'h69c4e0d86a7b0430d8cdb78070b4c55a},
      '{0, 0, 0, 0, 0, 0, CmdDecrypt, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1, {PH, PL}},
      '{0, 0, 0, 0, 0, 0, CmdEncrypt, 0, 0, 0, 0},
      '{0, 0, 0, 0, 0, 0, CmdEncrypt, ONES, ONES, 0, 0},
      '{0, 0, 0, 0, 0, 0, CmdDecrypt, ONES, ONES, 0, 0},
      '{0, 0, 0, 0, 0, 0, CmdDecrypt, 0, 0, 0, 0},
      '{1, 1, F0, F1, F2, 0, CmdEncrypt, PH, PL, 1, 128'hdda97ca4864cdfe06eaf70a0ec0d7191},
      '{0, 0, 0, 0, 0, 0, CmdDecrypt, 64'hdda97ca4864cdfe0, 64'h6eaf70a0ec0d7191, 1, {PH, PL}},
      '{0, 0, 0, 0, 0, 0, CmdEncrypt, ONES, 0, 0, 0},
      '{1, 2, F0, F1, F2, F3, CmdEncrypt, PH, PL, 1, 128'h8ea2b7ca516745bfeafc49904b496089},
      '{0, 0, 0, 0, 0, 0, CmdDecrypt, 64'h8ea2b7ca516745bf, 64'heafc49904b496089, 1, {PH, PL}},
      '{0, 0, 0, 0, 0, 0, CmdDecrypt, 0, ONES, 0, 0},
      // key size code three behaves as a 256-bit key
      '{1, 3, F0, F1, F2, F3, CmdEncrypt, PH, PL, 1, 128'h8ea2b7ca516745bfeafc49904b496089},
      '{0, 0, 0, 0, 0, 0, CmdDecrypt, ONES, ONES, 0, 0},
      // all-zero 128-bit key, upper key words must be ignored
      '{1, 0, 0, 0, ONES, ONES, CmdEncrypt, 0, 0, 1, 128'h66e94bd4ef8a2c3b884cfa59ca342b2e},
      '{0, 0, 0, 0, 0, 0, CmdDecrypt, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e, 1, 0},
      '{1, 2, ONES, ONES, ONES, ONES, CmdEncrypt, ONES, ONES, 0, 0},
      '{0, 0, 0, 0, 0, 0, CmdDecrypt, 0, 0, 0, 0},
      '{1, 1, ONES, ONES, ONES, 0, CmdEncrypt, 0, ONES, 0, 0},
      '{0, 0, 0, 0, 0, 0, CmdDecrypt, ONES, 0, 0, 0}
   };

   // ---------------- predictor ----------------
   bit [7:0] sbox_fwd [256] = '{
      8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
      8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
      8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
      8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
      8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
      8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
      8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
      8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
      8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
      8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
      8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
      8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
      8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
      8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
      8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
      8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16};
   bit [7:0]  sbox_inv [256];
   bit [1:0]  key_size_r;
   bit [63:0] key_r [4];
   bit [31:0] sched [60];

   function automatic bit [7:0] gmul(bit [7:0] a, bit [7:0] b);
      bit [7:0] p;
      p = 0;
      for (int k = 0; k < 8; k++) begin
         if (b[k]) p ^= a;
         a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
      end
      return p;
   endfunction

   function automatic bit [31:0] subw(bit [31:0] w);
      return {sbox_fwd[w[31:24]], sbox_fwd[w[23:16]], sbox_fwd[w[15:8]], sbox_fwd[w[7:0]]};
   endfunction

   function automatic int key_len_words();
      return (key_size_r == 0) ? 4 : (key_size_r == 1) ? 6 : 8;
   endfunction

   // rebuild the round key schedule from the register copies
   function automatic void expand_schedule();
      int nk;
      bit [31:0] t;
      bit [7:0] rc;
      nk = key_len_words();
      rc = 8'h01;
      for (int i = 0; i < nk; i++)
         sched[i] = i[0] ? key_r[i>>1][31:0] : key_r[i>>1][63:32];
      for (int i = nk; i < 4 * (nk + 7); i++) begin
         t = sched[i-1];
         if (i % nk == 0) begin
            t = subw({t[23:0], t[31:24]}) ^ {rc, 24'h0};
            rc = gmul(rc, 8'h02);
         end else if (nk == 8 && i % 8 == 4) begin
            t = subw(t);
         end
         sched[i] = sched[i-nk] ^ t;
      end
   endfunction

   function automatic void csr_apply(bit [2:0] idx, bit [63:0] val);
      case (idx)
         CsrKeySize: key_size_r = val[1:0];
         CsrKey0:    key_r[0] = val;
         CsrKey1:    key_r[1] = val;
         CsrKey2:    key_r[2] = val;
         CsrKey3:    key_r[3] = val;
         default:    return;
      endcase
      expand_schedule();
   endfunction

   function automatic bit [127:0] cipher_predict(bit cmd, bit [127:0] blk);
      bit [7:0] s [16];
      bit [7:0] o [16];
      bit [7:0] fm [4];
      bit [7:0] im [4];
      int nr;
      nr = key_len_words() + 6;
      fm = '{8'h02, 8'h03, 8'h01, 8'h01};
      im = '{8'h0E, 8'h0B, 8'h0D, 8'h09};
      for (int i = 0; i < 16; i++) s[i] = blk[127 - 8*i -: 8];
      for (int st = 0; st <= nr; st++) begin
         int rnd;
         rnd = (cmd == CmdEncrypt) ? st : nr - st;
         // forward: shift, sub, mix; inverse: shift, sub (the round key is added below)
         if (st > 0) begin
            o = s;
            for (int r = 1; r < 4; r++)
               for (int c = 0; c < 4; c++)
                  s[r + 4*c] = (cmd == CmdEncrypt) ? o[r + 4*((c + r) & 3)]
                                                   : o[r + 4*((c + 4 - r) & 3)];
            for (int i = 0; i < 16; i++)
               s[i] = (cmd == CmdEncrypt) ? sbox_fwd[s[i]] : sbox_inv[s[i]];
            if (cmd == CmdEncrypt && st < nr) begin
               o = s;
               for (int c = 0; c < 4; c++)
                  for (int r = 0; r < 4; r++)
                     s[4*c + r] = gmul(o[4*c], fm[(4 - r) & 3]) ^ gmul(o[4*c+1], fm[(5 - r) & 3])
                                ^ gmul(o[4*c+2], fm[(6 - r) & 3]) ^ gmul(o[4*c+3], fm[(7 - r) & 3]);
            end
         end
         for (int c = 0; c < 4; c++)
            for (int b = 0; b < 4; b++) s[4*c + b] ^= sched[4*rnd + c][31 - 8*b -: 8];
         // inverse mix follows the key addition in the middle rounds
         if (cmd == CmdDecrypt && st > 0 && st < nr) begin
            o = s;
            for (int c = 0; c < 4; c++)
               for (int r = 0; r < 4; r++)
                  s[4*c + r] = gmul(o[4*c], im[(4 - r) & 3]) ^ gmul(o[4*c+1], im[(5 - r) & 3])
                             ^ gmul(o[4*c+2], im[(6 - r) & 3]) ^ gmul(o[4*c+3], im[(7 - r) & 3]);
         end
      end
      for (int i = 0; i < 16; i++) blk[127 - 8*i -: 8] = s[i];
      return blk;
   endfunction

   // ---------------- bookkeeping ----------------
   bit [127:0] cipher_expected [$];
   int  mismatches, results_seen, blocks_sent, key_loads;
   int  idle_cycles;
   bit  hold_request, no_gaps;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // watchdog: cycles with no transaction on any channel
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("timeout: no transaction for %0d cycles", IdleLimit);
         $display("FAIL aes_block_cipher_unit");
         $finish;
      end
   end

   // result side: random stalls, one long hold on request
   initial begin
      int n;
      rsp_tready = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         n = no_gaps ? 0 : $urandom_range(0, 8);
         if (hold_request) begin
            n = 300;
            hold_request = 0;
         end
         if (n > 0) begin
            rsp_tready = 0;
            repeat (n) @(negedge clock);
         end
         rsp_tready = 1;
         do @(posedge clock); while (!rsp_tvalid);
         results_seen++;
         if (cipher_expected.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", rsp_tdata);
         end else begin
            bit [127:0] want;
            want = cipher_expected.pop_front();
            // result_hi sits in the low half of tdata
            if (rsp_tdata[63:0] !== want[127:64] || rsp_tdata[127:64] !== want[63:0]) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result %0d: expected hi=%h lo=%h, got hi=%h lo=%h", results_seen,
                           want[127:64], want[63:0], rsp_tdata[63:0], rsp_tdata[127:64]);
            end
         end
         @(negedge clock);
      end
   end

   task automatic wait_drained();
      while (cipher_expected.size() != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
   endtask

   task automatic csr_write(bit [2:0] idx, bit [63:0] val);
      csr_valid = 1;
      csr_index = idx;
      csr_data = val;
      do @(posedge clock); while (!csr_ready);
      csr_apply(idx, val);
      @(negedge clock);
      csr_valid = 0;
   endtask

   task automatic load_key(bit [1:0] ks, bit [63:0] k0, k1, k2, k3);
      req_tvalid = 0;
      wait_drained();
      csr_write(CsrKeySize, {62'h0, ks});
      csr_write(CsrKey0, k0);
      csr_write(CsrKey1, k1);
      csr_write(CsrKey2, k2);
      csr_write(CsrKey3, k3);
      key_loads++;
   endtask

   // offer one block; expectation is either given or predicted at acceptance
   task automatic send_block(bit cmd, bit [63:0] hi, lo, bit known, bit [127:0] ans);
      int n;
      n = no_gaps ? 0 : $urandom_range(0, 8);
      if (n > 0) begin
         req_tvalid = 0;
         repeat (n) @(negedge clock);
      end
      req_tvalid = 1;
      req_tuser = cmd;
      req_tdata = {lo, hi};
      do @(posedge clock); while (!req_tready);
      cipher_expected.push_back(known ? ans : cipher_predict(cmd, {hi, lo}));
      blocks_sent++;
      @(negedge clock);
   endtask

   function automatic bit [63:0] rand_word();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // ---------------- main sequence ----------------
   initial begin
      bit [63:0] k [4];
      req_tvalid = 0; req_tuser = 0; req_tdata = 0;
      csr_valid = 0; csr_index = 0; csr_data = 0;
      reset = 1;
      idle_cycles = 0;
      key_size_r = 0;
      key_r = '{default: 0};
      sched = '{default: 0};
      for (int i = 0; i < 256; i++) sbox_inv[sbox_fwd[i]] = i[7:0];
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed rows
      foreach (dir_rows[i]) begin
         if (dir_rows[i].rekey)
            load_key(dir_rows[i].ks, dir_rows[i].k0, dir_rows[i].k1, dir_rows[i].k2,
                     dir_rows[i].k3);
         send_block(dir_rows[i].cmd, dir_rows[i].hi, dir_rows[i].lo, dir_rows[i].known,
                    dir_rows[i].ans);
      end
      req_tvalid = 0;
      // a write to a nonexistent register changes nothing
      wait_drained();
      csr_write(CsrUnused, {$urandom, $urandom});
      send_block(CmdEncrypt, PH, PL, 0, 0);
      send_block(CmdDecrypt, PH, PL, 0, 0);

      // random phases, each with a fresh key and size
      for (int ph = 0; ph < 8; ph++) begin
         foreach (k[j]) k[j] = rand_word();
         req_tvalid = 0;
         load_key((ph < 4) ? ph[1:0] : 2'($urandom_range(0, 3)), k[0], k[1], k[2], k[3]);
         no_gaps = (ph == 2 || ph == 6);
         if (ph == 3) hold_request = 1;
         for (int n = 0; n < 175; n++) begin
            // one mid-phase pause until all results are back
            if (ph == 5 && n == 80) begin
               req_tvalid = 0;
               while (cipher_expected.size() != 0) @(negedge clock);
            end
            send_block(1'($urandom_range(0, 1)), rand_word(), rand_word(), 0, 0);
         end
      end
      req_tvalid = 0;
      no_gaps = 0;

      wait_drained();
      $display("sent %0d blocks under %0d key loads, %0d results checked, %0d mismatches",
               blocks_sent, key_loads, results_seen, mismatches);
      if (mismatches == 0 && cipher_expected.size() == 0)
         $display("PASS aes_block_cipher_unit");
      else
         $display("FAIL aes_block_cipher_unit");
      $finish;
   end

endmodule

### sim.f
+incdir+rtl
rtl/aes_pkg.sv
rtl/aes_ctrl.sv
rtl/aes_dpath.sv
rtl/aes_block_cipher_unit.sv
dv/testbench.sv
